>>> design/geq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graphic EQ package
// Shared constants, microcode types, band program and saturation helpers.
// ----------------------------------------------------------------------------
package geq_pkg;

  localparam int GEQ_BANDS     = 10;
  localparam int GEQ_CHANNELS  = 2;
  localparam int GEQ_COEF_BITS = 32;

  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_IN_BITS = 32;
  localparam int BAND_IN_BITS = 4;
  localparam int SEL_BITS     = 3;
  localparam int NCOEF        = 5;

  localparam int STATE_BITS  = 48;
  localparam int STATE_FRAC  = 12;
  localparam int ACC_BITS    = STATE_BITS + 2;
  // rounded product width; independent of the coefficient width
  localparam int SCALED_BITS = SAMPLE_BITS + STATE_FRAC + 4;
  localparam int YS_BITS     = STATE_BITS + 1 - STATE_FRAC;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  localparam int STEP_BITS = 3;
  localparam int PROG_LEN  = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } geq_state_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_X,
    MUL_Y
  } mul_src_t;

  typedef enum logic [1:0] {
    A_HOLD,
    A_YS,   // rounded product + z1
    A_Z1,   // rounded product + z2
    A_SUB   // acc_a - rounded product
  } acc_a_op_t;

  typedef enum logic [1:0] {
    B_HOLD,
    B_LOAD,
    B_SUB
  } acc_b_op_t;

  typedef struct packed {
    logic      coef_rd;   // read coefficient at pointer, advance pointer
    logic      st_rd;     // read delay pair
    logic      z_ld;      // latch delay pair
    mul_src_t  mul;
    acc_a_op_t op_a;
    acc_b_op_t op_b;
    logic      y_ld;      // band output from acc_a
    logic      band_end;  // write delays, x <= y, loop or finish
  } geq_uop_t;

  localparam geq_uop_t UOP_NOP = '{1'b0, 1'b0, 1'b0, MUL_NONE, A_HOLD, B_HOLD, 1'b0, 1'b0};

  // One band of the transposed DF-II biquad, one shared multiplier.
  localparam geq_uop_t GEQ_PROGRAM [PROG_LEN] = '{
    '{1'b1, 1'b1, 1'b0, MUL_NONE, A_HOLD, B_HOLD, 1'b0, 1'b0},  // fetch b0, delays
    '{1'b1, 1'b0, 1'b1, MUL_X,    A_HOLD, B_HOLD, 1'b0, 1'b0},  // b0*x, fetch b1
    '{1'b1, 1'b0, 1'b0, MUL_X,    A_YS,   B_HOLD, 1'b0, 1'b0},  // ys, b1*x, fetch b2
    '{1'b1, 1'b0, 1'b0, MUL_X,    A_Z1,   B_HOLD, 1'b1, 1'b0},  // y, b2*x, fetch a1
    '{1'b1, 1'b0, 1'b0, MUL_Y,    A_HOLD, B_LOAD, 1'b0, 1'b0},  // a1*y, fetch a2
    '{1'b0, 1'b0, 1'b0, MUL_Y,    A_SUB,  B_HOLD, 1'b0, 1'b0},  // a2*y
    '{1'b0, 1'b0, 1'b0, MUL_NONE, A_HOLD, B_SUB,  1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, MUL_NONE, A_HOLD, B_HOLD, 1'b0, 1'b1}   // write back
  };

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [ACC_BITS-1:0] v
  );
    logic [ACC_BITS-STATE_BITS:0] top;
    top = v[ACC_BITS-1:STATE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[STATE_BITS-1:0];
    end
    return v[ACC_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}} : {1'b0, {(STATE_BITS-1){1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [YS_BITS-1:0] v
  );
    logic [YS_BITS-SAMPLE_BITS:0] top;
    top = v[YS_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_BITS-1:0];
    end
    return v[YS_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

endpackage
`default_nettype wire

>>> design/geq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graphic EQ channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface geq_item_if import geq_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic                           channel;
  logic signed [SAMPLE_BITS-1:0]  sample_in;
  logic [BAND_IN_BITS-1:0]        band;
  logic [SEL_BITS-1:0]            coef_select;
  logic signed [COEF_IN_BITS-1:0] coef_value;

  modport source (
    output valid, command, channel, sample_in, band, coef_select, coef_value,
    input  ready
  );
  modport sink (
    input  valid, command, channel, sample_in, band, coef_select, coef_value,
    output ready
  );
endinterface

interface geq_result_if import geq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          out_channel;

  modport source (output valid, sample_out, out_channel, input ready);
  modport sink (input valid, sample_out, out_channel, output ready);
endinterface
`default_nettype wire

>>> design/geq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module geq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/geq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graphic EQ band datapath
// Shared multiplier, rounding, two accumulators and the band output, driven
// by one control word per cycle.
// ----------------------------------------------------------------------------
module geq_datapath import geq_pkg::*; #(
  parameter int COEF_BITS = GEQ_COEF_BITS
) (
  input  wire logic                         clk,
  input  wire geq_uop_t                     uop,
  input  wire logic                         start,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic        [COEF_BITS-1:0]  coef,
  input  wire logic signed [STATE_BITS-1:0] z1_in,
  input  wire logic signed [STATE_BITS-1:0] z2_in,
  output logic signed      [SAMPLE_BITS-1:0] x,
  output logic signed      [STATE_BITS-1:0] z1_out,
  output logic signed      [STATE_BITS-1:0] z2_out
);

  localparam int PW         = COEF_BITS + SAMPLE_BITS;
  localparam int PROD_SHIFT = COEF_BITS - 4 - STATE_FRAC;
  localparam logic signed [PW-1:0] PROD_HALF = PW'(1) << (PROD_SHIFT - 1);
  localparam logic signed [STATE_BITS:0] YS_HALF = (STATE_BITS + 1)'(1) << (STATE_FRAC - 1);

  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [STATE_BITS-1:0]  z1_r, z2_r;
  logic signed [PW-1:0]          prod;
  logic signed [ACC_BITS-1:0]    acc_a, acc_b;

  logic signed [PW-1:0]          coef_ext, opnd_ext, prod_rnd;
  logic signed [SCALED_BITS-1:0] scaled;
  logic signed [ACC_BITS-1:0]    scaled_ext;
  logic signed [STATE_BITS:0]    ys_rnd;
  logic signed [SAMPLE_BITS-1:0] y_next;

  always_comb begin
    coef_ext   = PW'($signed(coef));
    opnd_ext   = (uop.mul == MUL_Y) ? PW'(y) : PW'(x);
    // round half up, then floor shift
    prod_rnd   = prod + PROD_HALF;
    scaled     = prod_rnd[PW-1:PROD_SHIFT];
    scaled_ext = ACC_BITS'(scaled);
    ys_rnd     = (STATE_BITS + 1)'(sat_state(acc_a)) + YS_HALF;
    y_next     = sat_sample(ys_rnd[STATE_BITS:STATE_FRAC]);
  end

  always_ff @(posedge clk) begin
    if (uop.mul != MUL_NONE) begin
      prod <= coef_ext * opnd_ext;
    end
    if (uop.z_ld) begin
      z1_r <= z1_in;
      z2_r <= z2_in;
    end
    case (uop.op_a)
      A_YS:    acc_a <= scaled_ext + ACC_BITS'(z1_r);
      A_Z1:    acc_a <= scaled_ext + ACC_BITS'(z2_r);
      A_SUB:   acc_a <= acc_a - scaled_ext;
      default: acc_a <= acc_a;
    endcase
    case (uop.op_b)
      B_LOAD:  acc_b <= scaled_ext;
      B_SUB:   acc_b <= acc_b - scaled_ext;
      default: acc_b <= acc_b;
    endcase
    if (uop.y_ld) begin
      y <= y_next;
    end
    if (start) begin
      x <= sample;
    end else if (uop.band_end) begin
      x <= y;
    end
  end

  assign z1_out = sat_state(acc_a);
  assign z2_out = sat_state(acc_b);

endmodule
`default_nettype wire

>>> design/graphic_eq_biquad_cascade_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graphic EQ biquad cascade
// Stereo cascade of BANDS biquads run by an 8-step band microprogram.
// ----------------------------------------------------------------------------
// Filtered sample: ST_RUN runs the 8-step band program per band on one
// multiplier and one coefficient RAM read port, then ST_DONE loads the result
// register; a bypassed sample skips ST_RUN. A coefficient word is written in its
// accept cycle. Items are taken in ST_IDLE only, after the last result is loaded.
// Sync reset clears control, enable and delay valid bits (delays read as zero);
// coefficient RAM is undefined until written.
module graphic_eq_biquad_cascade_unit import geq_pkg::*; #(
  parameter int BANDS     = GEQ_BANDS,
  parameter int CHANNELS  = GEQ_CHANNELS,
  parameter int COEF_BITS = GEQ_COEF_BITS
) (
  input wire logic     clk,
  input wire logic     rst,
  geq_item_if.sink     item,
  geq_result_if.source result,
  input wire logic     cfg_we,
  input wire logic     cfg_wdata
);

  localparam int CDEPTH = BANDS * NCOEF;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int SDEPTH = BANDS * CHANNELS;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int BW     = (BANDS > 1) ? $clog2(BANDS) : 1;

  geq_state_t state, state_next;
  logic       eq_enable;
  logic       was_enabled;
  logic       channel_r;
  logic [STEP_BITS-1:0] step;
  logic [BW-1:0]        band_cnt;
  logic [SAW-1:0]       state_base;
  logic [CAW-1:0]       coef_ptr;
  logic [SDEPTH-1:0]    st_valid;
  logic                 st_valid_q;
  logic                 out_valid;

  logic       item_rdy, accept, is_sample, chan_ok, out_load, band_last, edge_clear;
  geq_uop_t   uop;
  logic [SAW-1:0]              st_addr;
  logic [CAW-1:0]              coef_waddr;
  logic                        coef_we;
  logic [COEF_BITS-1:0]        coef_q;
  logic [2*STATE_BITS-1:0]     st_q;
  logic signed [STATE_BITS-1:0] z1_in, z2_in, z1_new, z2_new;
  logic signed [SAMPLE_BITS-1:0] x;

  assign is_sample  = (item.command == CMD_SAMPLE);
  assign chan_ok    = 32'(item.channel) < CHANNELS;
  assign band_last  = (band_cnt == BW'(BANDS - 1));
  assign uop        = (state == ST_RUN) ? GEQ_PROGRAM[step] : UOP_NOP;
  assign st_addr    = state_base + SAW'(channel_r);
  assign accept     = item.valid && item_rdy;
  assign edge_clear = accept && is_sample && eq_enable && !was_enabled;
  assign coef_we    = accept && (item.command == CMD_COEF)
                      && (32'(item.band) < BANDS) && (32'(item.coef_select) < NCOEF);
  assign coef_waddr = CAW'(32'(item.band) * NCOEF + 32'(item.coef_select));

  always_comb begin
    state_next = state;
    item_rdy   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_rdy = 1'b1;
        if (item.valid && is_sample) begin
          state_next = (eq_enable && chan_ok) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (uop.band_end && band_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign item.ready = item_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      eq_enable   <= 1'b0;
      was_enabled <= 1'b0;
      step        <= '0;
      band_cnt    <= '0;
      state_base  <= '0;
      coef_ptr    <= '0;
      st_valid    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        eq_enable <= cfg_wdata;
      end
      if (accept && is_sample) begin
        was_enabled <= eq_enable;
        step        <= '0;
        band_cnt    <= '0;
        state_base  <= '0;
        coef_ptr    <= '0;
      end
      if (edge_clear) begin
        st_valid <= '0;
      end
      if (state == ST_RUN) begin
        if (uop.coef_rd) begin
          coef_ptr <= coef_ptr + CAW'(1);
        end
        if (uop.band_end) begin
          step                <= '0;
          band_cnt            <= band_cnt + BW'(1);
          state_base          <= state_base + SAW'(CHANNELS);
          st_valid[st_addr]   <= 1'b1;
        end else begin
          step <= step + STEP_BITS'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_valid_q <= st_valid[st_addr];
    if (accept && is_sample) begin
      channel_r <= item.channel;
    end
    if (out_load) begin
      result.sample_out  <= x;
      result.out_channel <= channel_r;
    end
  end

  assign result.valid = out_valid;

  // delay pairs never written since reset or the enable edge read as zero
  assign z1_in = st_valid_q ? st_q[2*STATE_BITS-1:STATE_BITS] : '0;
  assign z2_in = st_valid_q ? st_q[STATE_BITS-1:0] : '0;

  geq_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (item.coef_value[COEF_BITS-1:0]),
    .raddr (coef_ptr),
    .rdata (coef_q)
  );

  geq_ram #(
    .WIDTH (2 * STATE_BITS),
    .DEPTH (SDEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (uop.band_end),
    .waddr (st_addr),
    .wdata ({z1_new, z2_new}),
    .raddr (st_addr),
    .rdata (st_q)
  );

  geq_datapath #(
    .COEF_BITS (COEF_BITS)
  ) u_datapath (
    .clk    (clk),
    .uop    (uop),
    .start  (accept && is_sample),
    .sample (item.sample_in),
    .coef   (coef_q),
    .z1_in  (z1_in),
    .z2_in  (z2_in),
    .x      (x),
    .z1_out (z1_new),
    .z2_out (z2_new)
  );

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> 32'(band_cnt) < BANDS)
    else $error("band counter out of range");

  a_coef_ptr: assert property (@(posedge clk) disable iff (rst)
    uop.band_end |-> 32'(coef_ptr) == NCOEF * (32'(band_cnt) + 1))
    else $error("coefficient pointer out of step with band");

  a_edge_clear: assert property (@(posedge clk) disable iff (rst)
    edge_clear |=> st_valid == '0)
    else $error("delay state not cleared on enable edge");

endmodule
`default_nettype wire

>>> bench/graphic_eq_biquad_cascade_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graphic EQ biquad cascade testbench
// Feeds sample and coefficient words through the valid/ready item channel with
// random gaps and output stalls. Every enable setting is exercised. A fixed
// point model of the ten-band cascade predicts each result word, and each
// result is checked against it in order.
// ----------------------------------------------------------------------------
module graphic_eq_biquad_cascade_unit_tb;
  import geq_pkg::*;

  localparam int  LIMIT_CYCLES = 500000;
  localparam int  SETTLE       = 120;
  localparam int  PROD_SHIFT   = GEQ_COEF_BITS - 4 - STATE_FRAC;
  localparam int  PHASE_ITEMS  = 62;
  localparam logic EQ_BYPASS   = 1'b0;
  localparam logic EQ_FILTER   = 1'b1;
  localparam logic signed [COEF_IN_BITS-1:0] UNITY = 32'sh1000_0000;  // 1.0 in Q4.28

  typedef enum logic [SEL_BITS-1:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_sel_t;

  typedef struct packed {
    logic                           command;
    logic                           channel;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic [BAND_IN_BITS-1:0]        band;
    logic [SEL_BITS-1:0]            sel;
    logic signed [COEF_IN_BITS-1:0] coef;
  } eq_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          channel;
  } eq_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  geq_item_if   item_ch ();
  geq_result_if result_ch ();

  graphic_eq_biquad_cascade_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predictor state
  longint     coef_bank [GEQ_BANDS][NCOEF];
  longint     z1_mem [GEQ_BANDS][GEQ_CHANNELS];
  longint     z2_mem [GEQ_BANDS][GEQ_CHANNELS];
  logic       eq_on;
  logic       was_on;

  eq_word_t   pending_words [$];
  eq_result_t expected_out [$];
  eq_result_t head;
  eq_word_t   taken_word;
  logic       item_taken;
  int         idle_pct;
  int         err_count;
  int         cycle_count;

  function automatic longint clamp_bits(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint coef_mul(longint c, longint v);
    return round_half_up(c * v, PROD_SHIFT);
  endfunction

  function automatic void clear_delays();
    for (int b = 0; b < GEQ_BANDS; b++) begin
      for (int c = 0; c < GEQ_CHANNELS; c++) begin
        z1_mem[b][c] = 0;
        z2_mem[b][c] = 0;
      end
    end
  endfunction

  function automatic void cascade_predict(eq_word_t w);
    longint     x;
    longint     y;
    longint     ys;
    int         ch;
    eq_result_t r;
    if (w.command == CMD_COEF) begin
      if (w.band < GEQ_BANDS && w.sel < NCOEF) begin
        coef_bank[w.band][w.sel] = longint'($signed(w.coef));
      end
      return;
    end
    x = longint'($signed(w.sample));
    ch = int'(w.channel);
    if (eq_on) begin
      if (!was_on) begin
        clear_delays();
      end
      for (int b = 0; b < GEQ_BANDS; b++) begin
        ys = clamp_bits(coef_mul(coef_bank[b][COEF_B0], x) + z1_mem[b][ch], STATE_BITS);
        y = clamp_bits(round_half_up(ys, STATE_FRAC), SAMPLE_BITS);
        z1_mem[b][ch] = clamp_bits(coef_mul(coef_bank[b][COEF_B1], x)
                                   - coef_mul(coef_bank[b][COEF_A1], y) + z2_mem[b][ch],
                                   STATE_BITS);
        z2_mem[b][ch] = clamp_bits(coef_mul(coef_bank[b][COEF_B2], x)
                                   - coef_mul(coef_bank[b][COEF_A2], y), STATE_BITS);
        x = y;
      end
    end
    was_on = eq_on;
    r.sample = x[SAMPLE_BITS-1:0];
    r.channel = w.channel;
    expected_out.push_back(r);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int                            r;
    logic signed [SAMPLE_BITS-1:0] v;
    r = $urandom_range(99);
    v = SAMPLE_BITS'($urandom);
    if (r < 60) begin
      v = SAMPLE_BITS'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    end else if (r >= 85) begin
      case ($urandom_range(4))
        0: v = 24'sh7FFFFF;
        1: v = 24'sh800000;
        2: v = '0;
        3: v = -24'sd1;
        default: v = 24'sd1;
      endcase
    end
    return v;
  endfunction

  // mostly gentle gains; now and then a wild value that drives the rails
  function automatic logic signed [COEF_IN_BITS-1:0] pick_coef(logic [SEL_BITS-1:0] sel);
    logic signed [COEF_IN_BITS-1:0] v;
    if ($urandom_range(99) < 10) begin
      v = $urandom;
    end else if (sel == COEF_B0) begin
      v = UNITY + (int'($urandom_range(0, 1 << 27)) - (1 << 26));
    end else begin
      v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    end
    return v;
  endfunction

  function automatic eq_word_t sample_word(logic ch, logic signed [SAMPLE_BITS-1:0] s);
    eq_word_t w;
    w.command = CMD_SAMPLE;
    w.channel = ch;
    w.sample = s;
    w.band = BAND_IN_BITS'($urandom);
    w.sel = SEL_BITS'($urandom);
    w.coef = $urandom;
    return w;
  endfunction

  function automatic eq_word_t coef_word(logic [BAND_IN_BITS-1:0] band,
                                         logic [SEL_BITS-1:0] sel,
                                         logic signed [COEF_IN_BITS-1:0] value);
    eq_word_t w;
    w.command = CMD_COEF;
    w.channel = 1'($urandom);
    w.sample = SAMPLE_BITS'($urandom);
    w.band = band;
    w.sel = sel;
    w.coef = value;
    return w;
  endfunction

  task automatic write_enable(logic value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || item_ch.valid || expected_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_coefs(logic tame);
    for (int b = 0; b < GEQ_BANDS; b++) begin
      for (int s = 0; s < NCOEF; s++) begin
        if (tame) begin
          pending_words.push_back(coef_word(b[BAND_IN_BITS-1:0], s[SEL_BITS-1:0],
                                            s == COEF_B0 ? UNITY : '0));
        end else begin
          pending_words.push_back(coef_word(b[BAND_IN_BITS-1:0], s[SEL_BITS-1:0],
                                            pick_coef(s[SEL_BITS-1:0])));
        end
      end
    end
  endtask

  // driver: holds a word until it is taken, then maybe idles
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        taken_word = pending_words.pop_front();
        item_ch.command <= taken_word.command;
        item_ch.channel <= taken_word.channel;
        item_ch.sample_in <= taken_word.sample;
        item_ch.band <= taken_word.band;
        item_ch.coef_select <= taken_word.sel;
        item_ch.coef_value <= taken_word.coef;
        item_ch.valid <= 1'b1;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  // monitor: predicts on accepted items, checks accepted results
  always @(posedge clk) begin
    item_taken = 1'b0;
    if (rst) begin
      eq_on = 1'b0;
      was_on = 1'b0;
      clear_delays();
    end else begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("%0t: timeout", $time);
        $display("graphic_eq_biquad_cascade_unit: mismatch");
        $finish;
      end
      if (cfg_we) begin
        eq_on = cfg_wdata;
      end
      if (item_ch.valid && item_ch.ready) begin
        item_taken = 1'b1;
        cascade_predict('{item_ch.command, item_ch.channel, item_ch.sample_in, item_ch.band,
                          item_ch.coef_select, item_ch.coef_value});
      end
      if (result_ch.valid && result_ch.ready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected result word: ch %0d sample %0d", $time,
                   result_ch.out_channel, $signed(result_ch.sample_out));
          err_count++;
        end else begin
          head = expected_out.pop_front();
          if (result_ch.sample_out !== head.sample) begin
            $display("%0t: sample_out expected %0d got %0d", $time,
                     $signed(head.sample), $signed(result_ch.sample_out));
            err_count++;
          end
          if (result_ch.out_channel !== head.channel) begin
            $display("%0t: out_channel expected %0d got %0d", $time,
                     head.channel, result_ch.out_channel);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    logic                    phase_enable [8];
    int                      n;
    int                      r;
    logic [BAND_IN_BITS-1:0] band_pick;
    logic [SEL_BITS-1:0]     sel_pick;
    phase_enable = '{EQ_FILTER, EQ_FILTER, EQ_BYPASS, EQ_FILTER,
                     EQ_FILTER, EQ_BYPASS, EQ_BYPASS, EQ_FILTER};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_SAMPLE;
    item_ch.channel = 1'b0;
    item_ch.sample_in = '0;
    item_ch.band = '0;
    item_ch.coef_select = '0;
    item_ch.coef_value = '0;
    result_ch.ready = 1'b0;
    idle_pct = 17;
    err_count = 0;
    cycle_count = 0;
    item_taken = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bypass at the sample extremes, then a unity cascade
    write_enable(EQ_BYPASS);
    pending_words.push_back(sample_word(1'b0, 24'sh7FFFFF));
    pending_words.push_back(sample_word(1'b1, 24'sh800000));
    pending_words.push_back(sample_word(1'b0, '0));
    pending_words.push_back(sample_word(1'b1, -24'sd1));
    load_coefs(1'b1);
    // out of range band or selector: must not touch the store
    pending_words.push_back(coef_word(4'd10, COEF_B0, 32'sh7FFFFFFF));
    pending_words.push_back(coef_word(4'd15, COEF_A2, 32'sh7FFFFFFF));
    pending_words.push_back(coef_word(4'd3, 3'd5, 32'sh8000_0000));
    pending_words.push_back(coef_word(4'd0, 3'd7, 32'sh7FFFFFFF));
    wait_drained();

    write_enable(EQ_FILTER);
    pending_words.push_back(sample_word(1'b0, 24'sh7FFFFF));
    pending_words.push_back(sample_word(1'b1, 24'sh800000));
    pending_words.push_back(sample_word(1'b0, 24'sd1));
    pending_words.push_back(sample_word(1'b1, -24'sd1));
    // largest and most negative gain saturate the output
    pending_words.push_back(coef_word(4'd0, COEF_B0, 32'sh7FFFFFFF));
    pending_words.push_back(sample_word(1'b0, 24'sh7FFFFF));
    pending_words.push_back(sample_word(1'b1, 24'sh800000));
    pending_words.push_back(coef_word(4'd0, COEF_B0, 32'sh8000_0000));
    pending_words.push_back(sample_word(1'b0, 24'sh7FFFFF));
    pending_words.push_back(sample_word(1'b1, 24'sh800000));
    pending_words.push_back(coef_word(4'd0, COEF_B0, UNITY));
    // impulse through feedback in the last band
    pending_words.push_back(coef_word(4'd9, COEF_A1, 32'sh0800_0000));
    pending_words.push_back(coef_word(4'd9, COEF_B2, 32'sh0400_0000));
    pending_words.push_back(sample_word(1'b0, 24'sd100000));
    pending_words.push_back(sample_word(1'b0, '0));
    pending_words.push_back(sample_word(1'b1, '0));
    pending_words.push_back(sample_word(1'b0, '0));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      idle_pct = (p == 3) ? 0 : 17;
      write_enable(phase_enable[p]);
      if (p == 4) begin
        load_coefs(1'b0);
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 80) begin
          pending_words.push_back(sample_word(1'($urandom), pick_sample()));
          n++;
        end else if (r < 95) begin
          band_pick = BAND_IN_BITS'($urandom_range(0, GEQ_BANDS - 1));
          sel_pick = SEL_BITS'($urandom_range(0, NCOEF - 1));
          pending_words.push_back(coef_word(band_pick, sel_pick, pick_coef(sel_pick)));
          n++;
        end else if (r < 98) begin
          pending_words.push_back(coef_word(BAND_IN_BITS'($urandom_range(GEQ_BANDS, 15)),
                                            SEL_BITS'($urandom), $urandom));
        end else begin
          pending_words.push_back(coef_word(BAND_IN_BITS'($urandom),
                                            SEL_BITS'($urandom_range(NCOEF, 7)), $urandom));
        end
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("graphic_eq_biquad_cascade_unit: match");
    end else begin
      $display("graphic_eq_biquad_cascade_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> graphic_eq_biquad_cascade_unit.f
design/geq_pkg.sv
design/geq_if.sv
design/geq_ram.sv
design/geq_datapath.sv
design/graphic_eq_biquad_cascade_unit.sv
bench/graphic_eq_biquad_cascade_unit_tb.sv
